/* rtl/gbc_pkg.sv */
package gbc_pkg;

  localparam int AXES       = 3;
  localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int COUNT_W    = 16;
  localparam logic [COUNT_W-1:0] CAL_SAMPLES_RESET = 16'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;      // start a new collection
    logic accum;      // add the accepted sample to the sums
    logic div_first;  // start dividing the first axis
    logic div_next;   // start dividing the next axis
    logic load_out;   // load the corrected sample into the output stage
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_sample;  // this collected sample ends collection
    logic div_done;     // the divider finished the current axis
    logic last_axis;    // the current axis is the last one
  } status_t;

endpackage

/* rtl/gbc_div.sv */
module gbc_div
  import gbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sum_t                 dividend,
  input  logic [COUNT_W-1:0]   divisor,
  output logic                 done,
  output sample_t              quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic               neg;
  logic [COUNT_W-1:0] dsr;
  logic [COUNT_W-1:0] rem;
  logic [SUM_W-1:0]   quo;

  logic [COUNT_W:0]   rem_shift;
  logic               fits;
  logic [COUNT_W:0]   rem_sub;
  logic [SUM_W-1:0]   quo_neg;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign rem_sub   = rem_shift - {1'b0, dsr};
  assign quo_neg   = -quo;
  assign quotient  = neg ? sample_t'(quo_neg[SAMPLE_W-1:0]) : sample_t'(quo[SAMPLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      dsr <= (divisor == '0) ? COUNT_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/gbc_datapath.sv */
module gbc_datapath
  import gbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [COUNT_W-1:0]   cfg_wr_data,
  input  sample_t              rate_in [AXES],
  input  cmd_t                 cmd,
  output status_t              st,
  output sample_t              out_data [AXES]
);

  logic [COUNT_W-1:0] cal_samples;
  logic [COUNT_W-1:0] samples_taken;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W:0]   taken_inc;
  sum_t               sums [AXES];
  sample_t            offsets [AXES];
  logic [AXIS_W-1:0]  axis_sel;
  logic [AXIS_W-1:0]  div_axis;
  logic               div_done;
  sample_t            div_quo;

  assign eff_count = (cal_samples == '0) ? COUNT_W'(1) : cal_samples;
  assign taken_inc = {1'b0, samples_taken} + 1'b1;

  assign st.last_sample = taken_inc >= {1'b0, eff_count};
  assign st.div_done    = div_done;
  assign st.last_axis   = axis_sel == AXIS_W'(AXES - 1);

  assign div_axis = cmd.div_first ? '0 : AXIS_W'(axis_sel + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      cal_samples <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_taken <= '0;
    end else if (cmd.clear) begin
      samples_taken <= '0;
    end else if (cmd.accum) begin
      samples_taken <= taken_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_first || cmd.div_next) begin
      axis_sel <= div_axis;
    end
  end

  gbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_first || cmd.div_next),
    .dividend (sums[div_axis]),
    .divisor  (eff_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [SAMPLE_W:0] diff;

    assign diff = $signed({rate_in[a][SAMPLE_W-1], rate_in[a]})
                  - $signed({offsets[a][SAMPLE_W-1], offsets[a]});

    always_ff @(posedge clk) begin
      if (cmd.clear) begin
        sums[a] <= '0;
      end else if (cmd.accum) begin
        sums[a] <= sums[a] + SUM_W'(rate_in[a]);
      end
    end

    always_ff @(posedge clk) begin
      if (div_done && axis_sel == AXIS_W'(a)) begin
        offsets[a] <= div_quo;
      end
    end

    // Saturate the difference back to the sample range.
    always_ff @(posedge clk) begin
      if (cmd.load_out) begin
        if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
          out_data[a] <= diff[SAMPLE_W] ? sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}})
                                        : sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
        end else begin
          out_data[a] <= sample_t'(diff[SAMPLE_W-1:0]);
        end
      end
    end
  end

endmodule

/* rtl/gbc_ctrl.sv */
module gbc_ctrl
  import gbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [2:0] S_BOOT     = 3'd0;
  localparam logic [2:0] S_COLLECT  = 3'd1;
  localparam logic [2:0] S_COMPLETE = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_READY    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_acc;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_BOOT: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.clear  = 1'b1;
          state_next = S_COLLECT;
        end
      end
      S_COLLECT: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.accum = 1'b1;
          if (st.last_sample) begin
            state_next = S_COMPLETE;
          end
        end
      end
      S_COMPLETE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.div_first = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.last_axis) begin
            state_next = S_READY;
          end else begin
            cmd.div_next = 1'b1;
          end
        end
      end
      S_READY: begin
        // The output register frees up in the same cycle its request is taken.
        in_ready = !out_valid || out_ready;
        if (in_acc) begin
          cmd.load_out = 1'b1;
        end
      end
      default: begin
        state_next = S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/gyro_bias_calibrator.sv */
// Gyro zero-rate offset calibrator. After reset the first request is dropped, the next
// cal_samples requests (0 counts as 1) are summed per axis, and the request after those is
// dropped while each axis offset is found as sum / cal_samples, truncated toward zero. Every
// later request comes out with its offsets subtracted, saturated to 16 bits. Dropped and
// collected requests are taken without stalling. The dropped request that ends collection
// stalls the input while one shared radix-2 divider, 32 iterations per axis, works out the
// three offsets in turn. Once calibrated, the block takes one request per cycle unless a
// result waits in the output register and is not taken; a waiting result does not stop the
// next request from being taken when the result is taken in the same cycle.
module gyro_bias_calibrator
  import gbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [COUNT_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   rate_roll,
  input  logic signed [15:0]   rate_pitch,
  input  logic signed [15:0]   rate_yaw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_roll,
  output logic signed [15:0]   out_pitch,
  output logic signed [15:0]   out_yaw
);

  cmd_t    cmd;
  status_t st;
  sample_t rate_in [AXES];
  sample_t out_data [AXES];

  assign rate_in[0] = rate_roll;
  assign rate_in[1] = rate_pitch;
  assign rate_in[2] = rate_yaw;
  assign out_roll   = out_data[0];
  assign out_pitch  = out_data[1];
  assign out_yaw    = out_data[2];

  gbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  gbc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rate_in     (rate_in),
    .cmd         (cmd),
    .st          (st),
    .out_data    (out_data)
  );

  // No request is taken while the divider reports an axis offset done.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> !in_ready)
    else $error("request accepted while offsets were being computed");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (in_valid && in_ready))
    else $error("output loaded without an accepted request");

  a_next_axis: assert property (@(posedge clk) disable iff (rst)
    cmd.div_next |-> (st.div_done && !st.last_axis))
    else $error("divider restarted out of sequence");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

endmodule

/* sim/tb_gyro_bias_calibrator.sv */
`timescale 1ns / 1ps

module tb_gyro_bias_calibrator;
  import gbc_pkg::*;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_t;
  typedef enum logic [1:0] {CAL_BOOT, CAL_COLLECT, CAL_COMPLETE, CAL_READY} cal_phase_e;

  localparam sample_t S_MAX = 16'h7FFF;
  localparam sample_t S_MIN = 16'h8000;
  localparam int SAT_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_MIN = -(2 ** (SAMPLE_W - 1));
  // Idle wait before each config write; it also covers the offset divide.
  localparam int SETTLE_CYCLES = 120;
  localparam int READY_ITEMS = 1000;
  localparam int MAX_REPORTS = 100;

  // Tracks the calibration and holds the corrected samples still to come out.
  class offset_tracker;
    cal_phase_e phase;
    logic [COUNT_W-1:0] cal_samples;
    logic [COUNT_W-1:0] taken;
    sum_t sums [AXES];
    sample_t offsets [AXES];
    axes_t pending [$];
    int unsigned mismatches;
    string names [AXES] = '{"roll", "pitch", "yaw"};

    function new();
      phase = CAL_BOOT;
      cal_samples = CAL_SAMPLES_RESET;
      taken = '0;
      mismatches = 0;
      for (int a = 0; a < AXES; a++) begin
        sums[a] = '0;
        offsets[a] = '0;
      end
    endfunction

    function void take_sample(axes_t s);
      int eff;
      int d;
      axes_t corrected;
      eff = (cal_samples == '0) ? 1 : int'(cal_samples);
      case (phase)
        CAL_BOOT: begin
          phase = CAL_COLLECT;
          taken = '0;
          for (int a = 0; a < AXES; a++) sums[a] = '0;
        end
        CAL_COLLECT: begin
          for (int a = 0; a < AXES; a++) sums[a] += sample_t'(s[a]);
          taken++;
          if (taken >= eff) phase = CAL_COMPLETE;
        end
        CAL_COMPLETE: begin
          // Signed division truncates toward zero; only the low bits are kept.
          for (int a = 0; a < AXES; a++) begin
            d = sums[a] / eff;
            offsets[a] = d[SAMPLE_W-1:0];
          end
          phase = CAL_READY;
        end
        default: begin
          for (int a = 0; a < AXES; a++) begin
            d = int'(sample_t'(s[a])) - int'(offsets[a]);
            if (d > SAT_MAX) d = SAT_MAX;
            else if (d < SAT_MIN) d = SAT_MIN;
            corrected[a] = d[SAMPLE_W-1:0];
          end
          pending.push_back(corrected);
        end
      endcase
    endfunction

    function void check_output(axes_t got);
      axes_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got roll %0d pitch %0d yaw %0d",
                   $time, $signed(got[0]), $signed(got[1]), $signed(got[2]));
        return;
      end
      want = pending.pop_front();
      for (int a = 0; a < AXES; a++) begin
        if (got[a] !== want[a]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: out_%s expected %0d, got %0d", $time, names[a],
                     $signed(want[a]), $signed(got[a]));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t rate_roll = '0;
  sample_t rate_pitch = '0;
  sample_t rate_yaw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_roll;
  sample_t out_pitch;
  sample_t out_yaw;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  offset_tracker tracker = new();

  gyro_bias_calibrator dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rate_roll(rate_roll),
    .rate_pitch(rate_pitch),
    .rate_yaw(rate_yaw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_roll(out_roll),
    .out_pitch(out_pitch),
    .out_yaw(out_yaw)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_output({out_yaw, out_pitch, out_roll});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid is left high after acceptance; the next call either idles or
  // presents a new request in that same step.
  task automatic send_sample(input axes_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {rate_yaw, rate_pitch, rate_roll} <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_sample(s);
  endtask

  task automatic write_cal(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.cal_samples = value;
  endtask

  initial begin
    axes_t s;
    axes_t corner_collect [6] = '{
      {S_MAX, S_MIN, S_MAX},
      {S_MIN, S_MAX, S_MIN},
      {S_MAX, S_MAX, S_MAX},
      {S_MIN, S_MIN, S_MIN},
      {16'hFFFF, 16'h0001, 16'h0000},
      {16'h5555, 16'hAAAA, 16'h3039}
    };
    axes_t corner_ready [4] = '{
      {16'h0000, S_MIN, S_MAX},
      {S_MAX, S_MAX, S_MIN},
      {16'h0000, 16'h0000, 16'h0000},
      {S_MIN, 16'h0001, 16'hFFFF}
    };
    int unsigned idle_plan [4] = '{0, 66, 0, 34};
    int unsigned stall_plan [4] = '{0, 0, 66, 34};
    int bias [AXES];
    int target;
    int divisor;
    int v;
    int wait_cycles;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_stall_pct = 34;

    write_cal('1);
    // The first request after reset is dropped.
    send_sample({16'h0000, S_MIN, S_MAX});
    foreach (corner_collect[i]) send_sample(corner_collect[i]);

    // Each axis gets a steady bias with some noise, so offsets can be large.
    for (int a = 0; a < AXES; a++) bias[a] = int'($urandom_range(40000)) - 20000;
    target = $urandom_range(12, 30);
    write_cal(COUNT_W'(target));
    for (int i = 0; i < target - 7; i++) begin
      // Drop the count below what has been taken; the next request ends collection.
      if (i == target - 8) write_cal('0);
      for (int a = 0; a < AXES; a++) begin
        v = bias[a] + int'($urandom_range(4000)) - 2000;
        s[a] = v[SAMPLE_W-1:0];
      end
      send_sample(s);
    end

    // The divisor is read when the dropped request after collection comes in.
    write_cal(16'd1);
    divisor = ($urandom_range(3) == 0) ? $urandom_range(1, target) : target - 1;
    write_cal(COUNT_W'(divisor));
    send_sample({16'h5555, S_MAX, S_MIN});

    foreach (corner_ready[i]) send_sample(corner_ready[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (READY_ITEMS / 4) begin
        for (int a = 0; a < AXES; a++) begin
          case ($urandom_range(9))
            0: s[a] = S_MAX;
            1: s[a] = S_MIN;
            2: begin
              v = int'(tracker.offsets[a]) + int'($urandom_range(8)) - 4;
              s[a] = v[SAMPLE_W-1:0];
            end
            default: s[a] = SAMPLE_W'($urandom);
          endcase
        end
        send_sample(s);
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    wait_cycles = 0;
    while (tracker.pending.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      tracker.mismatches++;
      $display("%0t: %0d expected results never arrived", $time, tracker.pending.size());
    end
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* gyro_bias_calibrator.f */
rtl/gbc_pkg.sv
rtl/gbc_div.sv
rtl/gbc_datapath.sv
rtl/gbc_ctrl.sv
rtl/gyro_bias_calibrator.sv
sim/tb_gyro_bias_calibrator.sv
